FILE: hdl/rrcb_pkg.sv
package rrcb_pkg;

	localparam int unsigned SIDE_W  = 13;
	localparam int unsigned POS_W   = 12;
	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned DIST_W  = 15;
	localparam int unsigned MAG_W   = 13;
	localparam int unsigned SQ_W    = 2 * MAG_W;
	localparam int unsigned SUM_W   = SQ_W + 1;
	localparam int unsigned MIX_W   = 2 * CHAN_W;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned CFG_W   = 24;

	typedef enum logic [IDX_W-1:0] {
		REG_RECT_WIDTH    = 3'd0,
		REG_RECT_HEIGHT   = 3'd1,
		REG_RADIUS_TL     = 3'd2,
		REG_RADIUS_TR     = 3'd3,
		REG_RADIUS_BL     = 3'd4,
		REG_RADIUS_BR     = 3'd5,
		REG_FILL_RGB      = 3'd6,
		REG_FILL_ALPHA    = 3'd7
	} reg_index_t;

	typedef struct packed {
		logic en_s5;
		logic en_s6;
	} blend_en_t;

endpackage

FILE: hdl/rrcb_blend.sv
module rrcb_blend (
	input  logic                             clk,
	input  rrcb_pkg::blend_en_t              en,
	input  logic [rrcb_pkg::CHAN_W-1:0]      bg,
	input  logic [rrcb_pkg::CHAN_W-1:0]      fg,
	input  logic [rrcb_pkg::CHAN_W-1:0]      alpha,
	output logic [rrcb_pkg::CHAN_W-1:0]      res
);

	logic [rrcb_pkg::MIX_W-1:0] num_s5;
	logic [rrcb_pkg::MIX_W-1:0] num_d;
	logic [rrcb_pkg::MIX_W:0]   quot_d;
	logic [rrcb_pkg::CHAN_W-1:0] res_s6;

	assign num_d = bg * (8'd255 - alpha) + fg * alpha;

	// Exact floor division by 255 for any numerator up to 255 * 255.
	assign quot_d = {1'b0, num_s5} + 17'd1 + {9'd0, num_s5[15:8]};

	always_ff @(posedge clk) begin
		if (en.en_s5) begin
			num_s5 <= num_d;
		end
		if (en.en_s6) begin
			res_s6 <= quot_d[15:8];
		end
	end

	assign res = res_s6;

endmodule

FILE: hdl/rounded_rect_coverage_blend.sv
// Throughput: one pixel per cycle unless m_tready stalls the output; each of
// the six stages holds one pixel and a stage moves on whenever the stage
// after it is empty or moving.
// Reset: arst_n clears all stage valid bits and loads the register defaults
// (sides 1, radii 0, fill color 0, fill alpha 255).
module rounded_rect_coverage_blend #(
	parameter int unsigned MAX_SIDE = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [rrcb_pkg::IDX_W-1:0]          wr_index,
	input  logic [rrcb_pkg::CFG_W-1:0]          wr_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// col_offset[11:0], row_offset[23:12], bg_red[31:24], bg_green[39:32], bg_blue[47:40]
	input  logic [47:0]                         s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
	output logic [31:0]                         m_tdata,
	// covered[0]
	output logic                                m_tuser
);

	localparam int unsigned SW = rrcb_pkg::SIDE_W;
	localparam int unsigned PW = rrcb_pkg::POS_W;
	localparam int unsigned CW = rrcb_pkg::CHAN_W;
	localparam int unsigned DW = rrcb_pkg::DIST_W;
	localparam int unsigned MW = rrcb_pkg::MAG_W;

	logic [SW-1:0]   width_q, height_q;
	logic [CW-1:0]   rad_tl_q, rad_tr_q, rad_bl_q, rad_br_q;
	logic [23:0]     fill_rgb_q;
	logic [CW-1:0]   fill_alpha_q;
	logic [SW-1:0]   wr_side;

	always_comb begin
		if (32'(wr_data[SW-1:0]) > MAX_SIDE) begin
			wr_side = SW'(MAX_SIDE);
		end else begin
			wr_side = wr_data[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= SW'(1);
			height_q     <= SW'(1);
			rad_tl_q     <= '0;
			rad_tr_q     <= '0;
			rad_bl_q     <= '0;
			rad_br_q     <= '0;
			fill_rgb_q   <= '0;
			fill_alpha_q <= 8'hFF;
		end else if (wr_en) begin
			unique case (rrcb_pkg::reg_index_t'(wr_index))
				rrcb_pkg::REG_RECT_WIDTH:  width_q      <= wr_side;
				rrcb_pkg::REG_RECT_HEIGHT: height_q     <= wr_side;
				rrcb_pkg::REG_RADIUS_TL:   rad_tl_q     <= wr_data[CW-1:0];
				rrcb_pkg::REG_RADIUS_TR:   rad_tr_q     <= wr_data[CW-1:0];
				rrcb_pkg::REG_RADIUS_BL:   rad_bl_q     <= wr_data[CW-1:0];
				rrcb_pkg::REG_RADIUS_BR:   rad_br_q     <= wr_data[CW-1:0];
				rrcb_pkg::REG_FILL_RGB:    fill_rgb_q   <= wr_data[23:0];
				rrcb_pkg::REG_FILL_ALPHA:  fill_alpha_q <= wr_data[CW-1:0];
				default: ;
			endcase
		end
	end

	// Stage control.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	assign en_s6    = !v_s6 || m_tready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;
	assign m_tvalid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: quadrant and radius selection.
	logic [PW-1:0] col_in, row_in;
	logic          left_d, top_d;
	logic [CW-1:0] rad_d;

	assign col_in = s_tdata[11:0];
	assign row_in = s_tdata[23:12];
	assign left_d = {1'b0, col_in} <= (width_q >> 1);
	assign top_d  = {1'b0, row_in} <= (height_q >> 1);

	always_comb begin
		case ({top_d, left_d})
			2'b11:   rad_d = rad_tl_q;
			2'b10:   rad_d = rad_tr_q;
			2'b01:   rad_d = rad_bl_q;
			default: rad_d = rad_br_q;
		endcase
	end

	logic [PW-1:0] col_s1, row_s1;
	logic [CW-1:0] rad_s1;
	logic [CW-1:0] bgr_s1, bgg_s1, bgb_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			col_s1 <= col_in;
			row_s1 <= row_in;
			rad_s1 <= rad_d;
			bgr_s1 <= s_tdata[31:24];
			bgg_s1 <= s_tdata[39:32];
			bgb_s1 <= s_tdata[47:40];
		end
	end

	// Stage 2: corner distances.
	logic signed [DW-1:0] lo_x, hi_x, lo_y, hi_y;

	assign lo_x = $signed({7'd0, rad_s1}) - $signed({3'd0, col_s1});
	assign hi_x = $signed({3'd0, col_s1}) + $signed({7'd0, rad_s1}) + 15'sd1
		- $signed({2'd0, width_q});
	assign lo_y = $signed({7'd0, rad_s1}) - $signed({3'd0, row_s1});
	assign hi_y = $signed({3'd0, row_s1}) + $signed({7'd0, rad_s1}) + 15'sd1
		- $signed({2'd0, height_q});

	logic signed [DW-1:0] rx_s2, ry_s2;
	logic [CW-1:0]        rad_s2;
	logic [CW-1:0]        bgr_s2, bgg_s2, bgb_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			rx_s2  <= (lo_x > hi_x) ? lo_x : hi_x;
			ry_s2  <= (lo_y > hi_y) ? lo_y : hi_y;
			rad_s2 <= rad_s1;
			bgr_s2 <= bgr_s1;
			bgg_s2 <= bgg_s1;
			bgb_s2 <= bgb_s1;
		end
	end

	// Stage 3: squares. A distance at or below zero covers the pixel outright,
	// so only the positive magnitudes need squaring.
	logic [rrcb_pkg::SQ_W-1:0]  rx_sq_s3, ry_sq_s3;
	logic [rrcb_pkg::MIX_W-1:0] rad_sq_s3;
	logic                       inside_s3;
	logic [CW-1:0]              bgr_s3, bgg_s3, bgb_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			rx_sq_s3  <= rx_s2[MW-1:0] * rx_s2[MW-1:0];
			ry_sq_s3  <= ry_s2[MW-1:0] * ry_s2[MW-1:0];
			rad_sq_s3 <= rad_s2 * rad_s2;
			inside_s3 <= (rx_s2 <= 15'sd0) || (ry_s2 <= 15'sd0);
			bgr_s3    <= bgr_s2;
			bgg_s3    <= bgg_s2;
			bgb_s3    <= bgb_s2;
		end
	end

	// Stage 4: distance test and effective alpha.
	logic [rrcb_pkg::SUM_W-1:0] dist_sum;
	logic                       cov_d;
	logic                       cov_s4;
	logic [CW-1:0]              alpha_s4;
	logic [CW-1:0]              bgr_s4, bgg_s4, bgb_s4;

	assign dist_sum = {1'b0, rx_sq_s3} + {1'b0, ry_sq_s3};
	assign cov_d    = inside_s3 || (dist_sum < {11'd0, rad_sq_s3});

	always_ff @(posedge clk) begin
		if (en_s4) begin
			cov_s4   <= cov_d;
			alpha_s4 <= cov_d ? fill_alpha_q : '0;
			bgr_s4   <= bgr_s3;
			bgg_s4   <= bgg_s3;
			bgb_s4   <= bgb_s3;
		end
	end

	// Stages 5 and 6: blend products, then division by 255.
	rrcb_pkg::blend_en_t blend_en;
	logic [CW-1:0]       alpha_s5, alpha_s6;
	logic                cov_s5, cov_s6;
	logic [CW-1:0]       red_res, green_res, blue_res;

	assign blend_en.en_s5 = en_s5;
	assign blend_en.en_s6 = en_s6;

	always_ff @(posedge clk) begin
		if (en_s5) begin
			cov_s5   <= cov_s4;
			alpha_s5 <= alpha_s4;
		end
		if (en_s6) begin
			cov_s6   <= cov_s5;
			alpha_s6 <= alpha_s5;
		end
	end

	rrcb_blend u_blend_red (
		.clk   (clk),
		.en    (blend_en),
		.bg    (bgr_s4),
		.fg    (fill_rgb_q[23:16]),
		.alpha (alpha_s4),
		.res   (red_res)
	);

	rrcb_blend u_blend_green (
		.clk   (clk),
		.en    (blend_en),
		.bg    (bgg_s4),
		.fg    (fill_rgb_q[15:8]),
		.alpha (alpha_s4),
		.res   (green_res)
	);

	rrcb_blend u_blend_blue (
		.clk   (clk),
		.en    (blend_en),
		.bg    (bgb_s4),
		.fg    (fill_rgb_q[7:0]),
		.alpha (alpha_s4),
		.res   (blue_res)
	);

	assign m_tdata = {alpha_s6, blue_res, green_res, red_res};
	assign m_tuser = cov_s6;

endmodule
